// File: design/sed_pkg.sv
// shared types, character codes and result codes for the string escape decoder
package sed_pkg;

  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowX   = 8'h78;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChTab    = 8'h09;

  localparam logic [1:0] StChar = 2'd0;
  localparam logic [1:0] StEnd  = 2'd1;
  localparam logic [1:0] StErr  = 2'd2;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_char;
    logic [1:0] err_count;
    logic [7:0] err_first;
    logic [7:0] err_second;
    logic [7:0] err_third;
    logic       run_last;
  } result_t;

  // results of one decoded item, slot 0 first
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// File: design/sed_decode.sv
// input register, escape state and per-byte decode into up to two results
module sed_decode import sed_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       body_end_i,
  input  logic       room_i,
  output push_t      push_o
);

  typedef enum logic [3:0] {
    PH_NORMAL = 4'b0001,
    PH_ESC    = 4'b0010,
    PH_HEX1   = 4'b0100,
    PH_HEX2   = 4'b1000
  } phase_e;

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      v = {1'b0, c[3:0] + 4'd9};
    return v;
  endfunction

  // bit 8 set means the pair is not allowed
  function automatic logic [8:0] hex_pair(input logic [7:0] c1, input logic [7:0] c2);
    logic [4:0] hi;
    logic [4:0] lo;
    logic       bad;
    hi  = hex_value(c1);
    lo  = hex_value(c2);
    bad = 1'b0;
    if (hi[4] || lo[4]) bad = 1'b1;
    else if (hi[3]) bad = 1'b1;
    else if (hi[2:0] == 3'd0) bad = !(lo[3:0] == 4'd9 || lo[3:0] == 4'd10 || lo[3:0] == 4'd13);
    else if (hi[2:0] == 3'd1) bad = 1'b1;
    else if (hi[2:0] == 3'd7 && lo[3:0] == 4'd15) bad = 1'b1;
    return {bad, hi[3:0], lo[3:0]};
  endfunction

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       end_q;
  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       mute_q, mute_d;
  logic       drop_q, drop_d;
  logic       fire;
  logic       pre_v;
  result_t    pre;
  result_t    end_r;
  logic [7:0] esc_ch;
  logic       esc_ok;
  logic [8:0] pair;

  assign fire       = vld_q && room_i;
  assign in_ready_o = !vld_q || room_i;
  assign vld_d      = in_ready_o ? in_valid_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      phase_q <= PH_NORMAL;
      held_q  <= '0;
      mute_q  <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (fire) begin
        phase_q <= phase_d;
        held_q  <= held_d;
        mute_q  <= mute_d;
        drop_q  <= drop_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
      end_q  <= body_end_i;
    end
  end

  always_comb begin
    esc_ok = 1'b1;
    esc_ch = byte_q;
    unique case (byte_q)
      ChLowN:  esc_ch = ChLf;
      ChLowR:  esc_ch = ChCr;
      ChLowT:  esc_ch = ChTab;
      ChBslash,
      ChQuote: esc_ch = byte_q;
      default: esc_ok = 1'b0;
    endcase
  end

  assign pair = hex_pair(held_q, byte_q);

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    mute_d  = mute_q;
    drop_d  = drop_q;
    pre_v   = 1'b0;
    pre     = '0;
    end_r   = '0;
    end_r.status   = StEnd;
    end_r.run_last = 1'b1;
    push_o  = '0;

    if (!drop_q) begin
      unique case (phase_q)
        PH_NORMAL: begin
          if (byte_q == ChBslash) begin
            phase_d = PH_ESC;
          end else if (!mute_q) begin
            pre_v        = 1'b1;
            pre.status   = StChar;
            pre.out_char = byte_q;
          end
        end
        PH_ESC: begin
          phase_d = PH_NORMAL;
          if (esc_ok) begin
            if (!mute_q) begin
              pre_v        = 1'b1;
              pre.status   = StChar;
              pre.out_char = esc_ch;
            end
          end else if (byte_q == ChZero) begin
            mute_d = 1'b1;
          end else if (byte_q == ChLowX) begin
            phase_d = PH_HEX1;
          end else begin
            pre_v         = 1'b1;
            pre.status    = StErr;
            pre.err_count = 2'd1;
            pre.err_first = byte_q;
            drop_d        = 1'b1;
          end
        end
        PH_HEX1: begin
          held_d  = byte_q;
          phase_d = PH_HEX2;
        end
        PH_HEX2: begin
          phase_d = PH_NORMAL;
          if (!pair[8]) begin
            if (!mute_q) begin
              pre_v        = 1'b1;
              pre.status   = StChar;
              pre.out_char = pair[7:0];
            end
          end else begin
            pre_v          = 1'b1;
            pre.status     = StErr;
            pre.err_count  = 2'd3;
            pre.err_first  = ChLowX;
            pre.err_second = held_q;
            pre.err_third  = byte_q;
            drop_d         = 1'b1;
          end
        end
        default: phase_d = PH_NORMAL;
      endcase
    end

    if (end_q) begin
      // escape left open at the end of the token
      if (!drop_d) begin
        unique case (phase_d)
          PH_ESC: begin
            pre_v      = 1'b1;
            pre.status = StErr;
          end
          PH_HEX1: begin
            pre_v         = 1'b1;
            pre.status    = StErr;
            pre.err_count = 2'd1;
            pre.err_first = ChLowX;
          end
          PH_HEX2: begin
            pre_v          = 1'b1;
            pre.status     = StErr;
            pre.err_count  = 2'd2;
            pre.err_first  = ChLowX;
            pre.err_second = held_d;
          end
          default: ;
        endcase
      end
      phase_d = PH_NORMAL;
      held_d  = '0;
      mute_d  = 1'b0;
      drop_d  = 1'b0;
      if (pre_v) begin
        push_o.num = fire ? 2'd2 : 2'd0;
        push_o.r0  = pre;
        push_o.r1  = end_r;
      end else begin
        push_o.num = fire ? 2'd1 : 2'd0;
        push_o.r0  = end_r;
      end
    end else begin
      pre.run_last = 1'b1;
      push_o.num   = (fire && pre_v) ? 2'd1 : 2'd0;
      push_o.r0    = pre;
    end
  end

`ifndef SYNTHESIS
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(phase_q))
    else $error("escape phase not one-hot");
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && end_q |=> phase_q == PH_NORMAL && !mute_q && !drop_q)
    else $error("state not cleared after token end");
  a_two_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.num == 2'd2 |-> push_o.r1.status == StEnd && push_o.r0.status != StEnd)
    else $error("two results that are not a result then the end marker");
  a_drop_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && drop_q && !end_q |-> push_o.num == 2'd0)
    else $error("result while dropping");
`endif

endmodule

// File: design/sed_res_fifo.sv
// result queue taking up to two results per cycle and giving one per cycle while the output is ready
module sed_res_fifo import sed_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  output logic    room_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  result_t          mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             pop;
  logic [QPtrW-1:0] wr_p1;

  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  // room for two more results whatever leaves this cycle
  assign room_o      = cnt_q <= QCntW'(QDepth - 2);
  assign wr_p1       = wr_q + QPtrW'(1);
  assign out_o       = mem_q[rd_q];
  assign cnt_d       = cnt_q + QCntW'(push_i.num) - QCntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPtrW'(push_i.num);
      rd_q  <= rd_q + QPtrW'(pop);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.num == 2'd2) mem_q[wr_p1] <= push_i.r1;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count above depth");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> room_o)
    else $error("push without room");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && push_i.num == 2'd0 |=> cnt_q == $past(cnt_q) - QCntW'(1))
    else $error("queue count did not drop on pop");
`endif

endmodule

// File: design/string_escape_decoder_unit.sv
// top level of the string escape decoder: stream ports, decoder and result queue
// an accepted item is held in the input register, decoded, and its results written into the result queue
// throughput: one item per cycle while each item gives at most one result and the output is not stalled
// an item that gives two results (a character or error, then the end) writes both at once; they leave one at a time
// the four-entry result queue limits this rate; input stalls while it holds over two
// reset: asynchronous active low, clears escape state, input valid flag and queue pointers and count
module string_escape_decoder_unit import sed_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  input  logic        s_tlast,   // body_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_char, err_count, err_first, err_second, err_third
  output logic [1:0]  m_tuser,   // status
  output logic        m_tlast    // run_last
);

  push_t   push;
  logic    room;
  result_t res;

  sed_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .in_ready_o (s_tready),
    .in_byte_i  (s_tdata),
    .body_end_i (s_tlast),
    .room_i     (room),
    .push_o     (push)
  );

  sed_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_o       (res)
  );

  assign m_tdata = {6'd0, res.err_third, res.err_second, res.err_first,
                    res.err_count, res.out_char};
  assign m_tuser = res.status;
  assign m_tlast = res.run_last;

endmodule

// File: tb/tb_string_escape_decoder_unit.sv
// self-checking testbench for the string escape decoder: directed tokens, then random token streams
`timescale 1ns / 100ps

module tb_string_escape_decoder_unit;
  import sed_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 20;

  typedef enum logic [1:0] {PhPlain, PhEscape, PhHexHi, PhHexLo} esc_phase_e;
  typedef logic [7:0] body_q_t[$];

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;    // in_byte
  logic        s_tlast  = 1'b0;  // body_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;          // out_char, err_count, err_first, err_second, err_third
  logic [1:0]  m_tuser;          // status
  logic        m_tlast;          // run_last

  string_escape_decoder_unit DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #1 clk_i = ~clk_i;

  // decoder state as predicted from the accepted items
  esc_phase_e phase_q    = PhPlain;
  logic [7:0] hex_hi_q   = '0;
  logic       muted_q    = 1'b0;
  logic       dropping_q = 1'b0;

  result_t pending_results[$];
  int      fail_count  = 0;
  int      items_sent  = 0;
  int      cycle_count = 0;
  int      tx_idle_pct = 8;
  int      rx_idle_pct = 45;

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= ChZero && c <= "9") return 5'(c - ChZero);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
    return 5'd16;
  endfunction

  // bit 8 set when the pair is not a legal hex escape
  function automatic logic [8:0] hex_pair_value(input logic [7:0] hi_c, input logic [7:0] lo_c);
    logic [4:0] hi;
    logic [4:0] lo;
    logic [7:0] v;
    hi = hex_nibble(hi_c);
    lo = hex_nibble(lo_c);
    if (hi[4] || lo[4]) return 9'h100;
    v = {hi[3:0], lo[3:0]};
    if (v == ChTab || v == ChLf || v == ChCr || (v >= 8'h20 && v <= 8'h7E)) return {1'b0, v};
    return 9'h100;
  endfunction

  function automatic result_t make_result(input logic [1:0] st, input logic [7:0] ch,
                                          input logic [1:0] cnt, input logic [7:0] e1,
                                          input logic [7:0] e2, input logic [7:0] e3);
    result_t r;
    r.status     = st;
    r.out_char   = ch;
    r.err_count  = cnt;
    r.err_first  = e1;
    r.err_second = e2;
    r.err_third  = e3;
    r.run_last   = 1'b0;
    return r;
  endfunction

  task automatic predict_item(input logic [7:0] b, input logic last);
    result_t    step_res[$];
    result_t    tail;
    logic [7:0] ch;
    logic       known;
    logic [8:0] pair;
    if (!dropping_q) begin
      case (phase_q)
        PhPlain: begin
          if (b == ChBslash) phase_q = PhEscape;
          else if (!muted_q)
            step_res.insert(step_res.size(), make_result(StChar, b, '0, '0, '0, '0));
        end
        PhEscape: begin
          phase_q = PhPlain;
          known = 1'b1;
          ch = '0;
          case (b)
            ChLowN: ch = ChLf;
            ChLowR: ch = ChCr;
            ChLowT: ch = ChTab;
            ChBslash, ChQuote: ch = b;
            default: known = 1'b0;
          endcase
          if (known) begin
            if (!muted_q)
              step_res.insert(step_res.size(), make_result(StChar, ch, '0, '0, '0, '0));
          end else if (b == ChZero) begin
            muted_q = 1'b1;
          end else if (b == ChLowX) begin
            phase_q = PhHexHi;
          end else begin
            step_res.insert(step_res.size(), make_result(StErr, '0, 2'd1, b, '0, '0));
            dropping_q = 1'b1;
          end
        end
        PhHexHi: begin
          hex_hi_q = b;
          phase_q = PhHexLo;
        end
        default: begin
          phase_q = PhPlain;
          pair = hex_pair_value(hex_hi_q, b);
          if (!pair[8]) begin
            if (!muted_q)
              step_res.insert(step_res.size(), make_result(StChar, pair[7:0], '0, '0, '0, '0));
          end else begin
            step_res.insert(step_res.size(), make_result(StErr, '0, 2'd3, ChLowX, hex_hi_q, b));
            dropping_q = 1'b1;
          end
        end
      endcase
    end
    if (last) begin
      // an escape left open at the end of the body is reported before the end marker
      if (!dropping_q) begin
        case (phase_q)
          PhEscape: step_res.insert(step_res.size(), make_result(StErr, '0, 2'd0, '0, '0, '0));
          PhHexHi:
            step_res.insert(step_res.size(), make_result(StErr, '0, 2'd1, ChLowX, '0, '0));
          PhHexLo:
            step_res.insert(step_res.size(), make_result(StErr, '0, 2'd2, ChLowX, hex_hi_q, '0));
          default: ;
        endcase
      end
      step_res.insert(step_res.size(), make_result(StEnd, '0, '0, '0, '0, '0));
      phase_q    = PhPlain;
      hex_hi_q   = '0;
      muted_q    = 1'b0;
      dropping_q = 1'b0;
    end
    if (step_res.size() > 0) begin
      tail = step_res.pop_back();
      tail.run_last = 1'b1;
      step_res.insert(step_res.size(), tail);
    end
    foreach (step_res[i]) pending_results.insert(pending_results.size(), step_res[i]);
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    predict_item(b, last);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_token(input body_q_t body);
    foreach (body[i]) send_item(body[i], i == body.size() - 1);
  endtask

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 4'd10) return ChZero + 8'(n);
    return ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
  endfunction

  function automatic body_q_t well_formed_token();
    body_q_t    body;
    int         pieces;
    int         kind;
    logic [7:0] v;
    pieces = $urandom_range(1, 8);
    repeat (pieces) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        body.insert(body.size(), 8'($urandom_range(0, 255)));
      end else if (kind < 60) begin
        case ($urandom_range(0, 4))
          0: v = ChLowN;
          1: v = ChLowR;
          2: v = ChLowT;
          3: v = ChBslash;
          default: v = ChQuote;
        endcase
        body.insert(body.size(), ChBslash);
        body.insert(body.size(), v);
      end else if (kind < 62) begin
        body.insert(body.size(), ChBslash);
        body.insert(body.size(), ChZero);
      end else if (kind < 80) begin
        case ($urandom_range(0, 3))
          0: v = ChTab;
          1: v = ChLf;
          2: v = ChCr;
          default: v = 8'($urandom_range(32, 126));
        endcase
        body.insert(body.size(), ChBslash);
        body.insert(body.size(), ChLowX);
        body.insert(body.size(), hex_digit(v[7:4]));
        body.insert(body.size(), hex_digit(v[3:0]));
      end else if (kind < 86) begin
        // mostly hex digits outside the legal range, sometimes not hex at all
        body.insert(body.size(), ChBslash);
        body.insert(body.size(), ChLowX);
        body.insert(body.size(),
                    ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : hex_digit(4'($urandom_range(0, 15))));
        body.insert(body.size(),
                    ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                : hex_digit(4'($urandom_range(0, 15))));
      end else if (kind < 90) begin
        do v = 8'($urandom_range(0, 255));
        while (v inside {ChLowN, ChLowR, ChLowT, ChBslash, ChQuote, ChZero, ChLowX});
        body.insert(body.size(), ChBslash);
        body.insert(body.size(), v);
      end else begin
        body.insert(body.size(), 8'($urandom_range(32, 126)));
      end
    end
    // sometimes the body stops inside an escape
    case ($urandom_range(0, 11))
      0: body.insert(body.size(), ChBslash);
      1: begin
        body.insert(body.size(), ChBslash);
        body.insert(body.size(), ChLowX);
      end
      2: begin
        body.insert(body.size(), ChBslash);
        body.insert(body.size(), ChLowX);
        body.insert(body.size(), hex_digit(4'($urandom_range(0, 15))));
      end
      default: ;
    endcase
    return body;
  endfunction

  function automatic body_q_t noise_token();
    body_q_t body;
    int      len;
    len = $urandom_range(1, 10);
    repeat (len) begin
      case ($urandom_range(0, 2))
        0: body.insert(body.size(), ChBslash);
        1: body.insert(body.size(), ($urandom_range(0, 1) == 0)
                                    ? ChLowX : hex_digit(4'($urandom_range(0, 15))));
        default: body.insert(body.size(), 8'($urandom_range(0, 255)));
      endcase
    end
    return body;
  endfunction

  task automatic test_plain_and_escapes();
    body_q_t body;
    // every simple escape, a legal hex at the top of the range, then a short hex at the end
    body = '{ChBslash, ChLowN, ChBslash, ChLowR, ChBslash, ChLowT, ChBslash, ChBslash,
             ChBslash, ChQuote, ChBslash, ChLowX, "7", "e", ChBslash, ChLowX, "A"};
    send_token(body);
  endtask

  task automatic test_mute_and_bad_hex();
    body_q_t body;
    // plain extremes, then mute; the bad hex pair still reports while muted
    body = '{8'h00, 8'hFF, ChBslash, ChZero, ChBslash, ChLowX, "7", "F"};
    send_token(body);
  endtask

  task automatic test_truncated_escapes();
    body_q_t body;
    body = '{ChBslash};
    send_token(body);
    body = '{ChBslash, ChLowX};
    send_token(body);
  endtask

  task automatic test_unknown_escape();
    body_q_t body;
    body = '{ChBslash, "q", 8'h5A};
    send_token(body);
  endtask

  task automatic test_random_tokens(input int tx_pct, input int rx_pct, input int n_items);
    body_q_t body;
    int      stop_at;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      body = ($urandom_range(0, 7) == 0) ? noise_token() : well_formed_token();
      send_token(body);
    end
  endtask

  always @(negedge clk_i) m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

  task automatic compare_field(input string field, input logic [7:0] want, input logic [7:0] seen);
    if (want !== seen) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual status %0h tdata %0h",
                 $time, m_tuser, m_tdata);
      end else begin
        want = pending_results.pop_front();
        compare_field("status", 8'(want.status), 8'(m_tuser));
        compare_field("out_char", want.out_char, m_tdata[7:0]);
        compare_field("err_count", 8'(want.err_count), 8'(m_tdata[9:8]));
        compare_field("err_first", want.err_first, m_tdata[17:10]);
        compare_field("err_second", want.err_second, m_tdata[25:18]);
        compare_field("err_third", want.err_third, m_tdata[33:26]);
        compare_field("run_last", 8'(want.run_last), 8'(m_tlast));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_plain_and_escapes();
    test_mute_and_bad_hex();
    test_truncated_escapes();
    test_unknown_escape();
    test_random_tokens(8, 45, 540);
    test_random_tokens(45, 8, 540);
    test_random_tokens(0, 0, 540);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
design/sed_pkg.sv
design/sed_decode.sv
design/sed_res_fifo.sv
design/string_escape_decoder_unit.sv
tb/tb_string_escape_decoder_unit.sv
